[rtl/triv_pkg.sv]
package triv_pkg;

    localparam int WORD_W     = 32;
    localparam int STATE_WORDS = 10;
    localparam int INIT_STEPS = 36;
    localparam int CNT_W      = $clog2(INIT_STEPS);
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int HALF_W     = 16;
    localparam int BYTES      = WORD_W / 8;

    localparam logic [7:0] C_PAD = 8'h70;

    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_CRYPT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IV_LOW   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH  = 2'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [STATE_WORDS-1:0][WORD_W-1:0] t_state;

    // 32 state bits out of the word pair hi:lo, starting sh bits up
    function automatic t_word tap(input t_word hi, input t_word lo, input int unsigned sh);
        logic [2*WORD_W-1:0] v;
        v = {hi, lo} >> sh;
        return v[WORD_W-1:0];
    endfunction

endpackage

[rtl/triv_step.sv]
module triv_step (
    input  triv_pkg::t_state i_state,
    output triv_pkg::t_state o_state,
    output triv_pkg::t_word  o_ks
);

    triv_pkg::t_word a2, a3, b2, b3, c2, c3, c4;
    triv_pkg::t_word ta, tb, tc, fa, fb, fc;

    assign a2 = i_state[1];
    assign a3 = i_state[2];
    assign b2 = i_state[4];
    assign b3 = i_state[5];
    assign c2 = i_state[7];
    assign c3 = i_state[8];
    assign c4 = i_state[9];

    // linear taps 66/93, 69/84, 66/111
    assign ta = triv_pkg::tap(a3, a2, 2)  ^ triv_pkg::tap(a3, a2, 29);
    assign tb = triv_pkg::tap(b3, b2, 5)  ^ triv_pkg::tap(b3, b2, 20);
    assign tc = triv_pkg::tap(c3, c2, 2)  ^ triv_pkg::tap(c4, c3, 15);

    assign o_ks = ta ^ tb ^ tc;

    // and-gate feedback, crossed into the next register
    assign fa = ta ^ (triv_pkg::tap(a3, a2, 27) & triv_pkg::tap(a3, a2, 28))
                   ^ triv_pkg::tap(b3, b2, 14);
    assign fb = tb ^ (triv_pkg::tap(b3, b2, 18) & triv_pkg::tap(b3, b2, 19))
                   ^ triv_pkg::tap(c3, c2, 23);
    assign fc = tc ^ (triv_pkg::tap(c4, c3, 13) & triv_pkg::tap(c4, c3, 14))
                   ^ triv_pkg::tap(a3, a2, 5);

    always_comb begin
        o_state    = i_state;
        o_state[2] = i_state[1];
        o_state[1] = i_state[0];
        o_state[0] = fc;
        o_state[5] = i_state[4];
        o_state[4] = i_state[3];
        o_state[3] = fa;
        o_state[9] = i_state[8];
        o_state[8] = i_state[7];
        o_state[7] = i_state[6];
        o_state[6] = fb;
    end

endmodule

[rtl/trivium_stream_cipher.sv]
// trivium keystream generator, 80-bit key and iv, 32 rounds per clock
//
// configuration: write key_low, key_high, iv_low, iv_high through i_cfg_we,
// i_cfg_idx and i_cfg_data while the block is idle; writes take effect at once.
// input channel (i_in_valid / o_in_ready) carries opcode, data word and byte count.
// init beat: loads key and iv into the state, then runs the shared
// 32-round step until 1152 rounds are done; o_in_ready stays low while they run
// and no output beat is made.
// crypt beat: the step unit advances the state one word and the
// masked xor lands in the output register, visible the cycle after accept.
// bytes beyond the byte count read as zero. sustained rate is one crypt beat
// per cycle while the receiver keeps i_out_ready high.
// output channel (o_out_valid / i_out_ready): the result holds in its register
// until taken; a new beat is accepted in the same cycle the old one leaves, so
// a stalled receiver stalls the input side.
// reset (synchronous, active low) clears key, iv, state, the busy flag and the output valid.
module trivium_stream_cipher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [triv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [triv_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_opcode,
    input  logic [31:0]                         i_data_in,
    input  logic [2:0]                          i_byte_count,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [31:0]                         o_data_out
);

    logic [triv_pkg::CFG_W-1:0]  r_key_low, r_iv_low;
    logic [triv_pkg::HALF_W-1:0] r_key_high, r_iv_high;
    triv_pkg::t_state            r_state, n_state, step_state, load_state;
    triv_pkg::t_word             ks, mask;
    logic                        r_busy;
    logic [triv_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_out_valid;
    logic [31:0]                 r_data_out;
    logic                        in_fire;

    triv_step u_step (
        .i_state (r_state),
        .o_state (step_state),
        .o_ks    (ks)
    );

    assign o_in_ready  = !r_busy && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;

    always_comb begin
        load_state    = '0;
        load_state[0] = r_key_low[31:0];
        load_state[1] = r_key_low[63:32];
        load_state[2] = {16'h0, r_key_high};
        load_state[3] = r_iv_low[31:0];
        load_state[4] = r_iv_low[63:32];
        load_state[5] = {16'h0, r_iv_high};
        load_state[9] = {16'h0, triv_pkg::C_PAD, 8'h00};
    end

    // byte lane enable; counts of four or more enable all lanes
    always_comb begin
        for (int i = 0; i < triv_pkg::BYTES; i++) begin
            mask[8*i +: 8] = {8{i_byte_count > 3'(i)}};
        end
    end

    always_comb begin
        n_state = r_state;
        if (r_busy) begin
            n_state = step_state;
        end else if (in_fire) begin
            if (i_opcode == triv_pkg::OP_INIT) begin
                n_state = load_state;
            end else begin
                n_state = step_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                triv_pkg::REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                triv_pkg::REG_KEY_HIGH: r_key_high <= i_cfg_data[triv_pkg::HALF_W-1:0];
                triv_pkg::REG_IV_LOW:   r_iv_low   <= i_cfg_data;
                triv_pkg::REG_IV_HIGH:  r_iv_high  <= i_cfg_data[triv_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == triv_pkg::CNT_W'(triv_pkg::INIT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end else if (in_fire && i_opcode == triv_pkg::OP_INIT) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end
            if (in_fire && i_opcode == triv_pkg::OP_CRYPT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_opcode == triv_pkg::OP_CRYPT) begin
            r_data_out <= (i_data_in ^ ks) & mask;
        end
    end

endmodule
